// File: src/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg: shared types and constants of the look-at view matrix block
// Vector bundles, the side band that travels with an item, row results.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int AXIS_FRAC  = 30;
  localparam int NORM_SH    = 6;   // leading-zero shift stages: 32,16,8,4,2,1
  localparam int SQRT_STEPS = 32;  // one root digit per stage
  localparam int DIV_STEPS  = 31;  // one quotient bit per stage

  localparam logic [1:0] ROW_SIDE = 2'd0;
  localparam logic [1:0] ROW_UP   = 2'd1;
  localparam logic [1:0] ROW_FWD  = 2'd2;

  typedef logic [2:0][31:0] v32_t;
  typedef logic [2:0][63:0] v64_t;

  // carried alongside an item: eye point, two vectors, running ok flag
  typedef struct packed {
    v32_t eye;
    v32_t p;
    v32_t q;
    logic flag;
  } side_t;

  typedef struct packed {
    v32_t        axis;
    logic [31:0] off;
  } row_t;

  typedef struct packed {
    row_t [2:0] rows;
    logic       degen;
  } block_t;

endpackage

// File: src/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm: pipelined vector normaliser
// Scales the largest magnitude into [2^29, 2^30), takes the integer root of
// the sum of squares and divides each component by it, giving Q2.30.
// ----------------------------------------------------------------------------
module lav_norm import lav_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  vld_in,
  input  v64_t  vec_in,
  input  side_t side_in,
  output logic  vld_out,
  output v32_t  unit_out,
  output logic  ok_out,
  output side_t side_out
);

  typedef struct packed {
    logic [2:0][29:0] m;
    logic [2:0]       neg;
    logic             zero;
    side_t            side;
  } nrm_t;

  // magnitudes
  logic             vld0;
  logic [2:0][62:0] mag0;
  logic [2:0]       neg0;
  side_t            side0;

  always_ff @(posedge clk) begin
    if (rst) vld0 <= 1'b0;
    else     vld0 <= vld_in;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg0[i] <= vec_in[i][63];
      mag0[i] <= vec_in[i][63] ? 63'(-vec_in[i]) : vec_in[i][62:0];
    end
    side0 <= side_in;
  end

  // largest magnitude, then leading-zero shifts
  logic [62:0]      top01, top_c;
  logic             vs [NORM_SH+1];
  logic [2:0][62:0] mg [NORM_SH+1];
  logic [62:0]      tp [NORM_SH+1];
  logic [2:0]       ng [NORM_SH+1];
  logic             zr [NORM_SH+1];
  side_t            sd [NORM_SH+1];

  assign top01 = (mag0[0] > mag0[1]) ? mag0[0] : mag0[1];
  assign top_c = (top01 > mag0[2]) ? top01 : mag0[2];

  always_ff @(posedge clk) begin
    if (rst) vs[0] <= 1'b0;
    else     vs[0] <= vld0;
  end

  always_ff @(posedge clk) begin
    mg[0] <= mag0;
    tp[0] <= top_c;
    ng[0] <= neg0;
    zr[0] <= (top_c == '0);
    sd[0] <= side0;
  end

  for (genvar k = 0; k < NORM_SH; k++) begin : g_sh
    localparam int SH = 32 >> k;
    logic hit;
    assign hit = (tp[k][62 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (rst) vs[k+1] <= 1'b0;
      else     vs[k+1] <= vs[k];
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        mg[k+1][i] <= hit ? (mg[k][i] << SH) : mg[k][i];
      end
      tp[k+1] <= hit ? (tp[k] << SH) : tp[k];
      ng[k+1] <= ng[k];
      zr[k+1] <= zr[k];
      sd[k+1] <= sd[k];
    end
  end

  // squares and their sum
  logic [2:0][29:0] mn;
  logic             vsq, vsum;
  logic [2:0][59:0] sq;
  nrm_t             csq, csum;
  logic [61:0]      len2;

  always_comb begin
    for (int i = 0; i < 3; i++) mn[i] = mg[NORM_SH][i][62:33];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vsq  <= 1'b0;
      vsum <= 1'b0;
    end else begin
      vsq  <= vs[NORM_SH];
      vsum <= vsq;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) sq[i] <= 60'(mn[i]) * 60'(mn[i]);
    csq.m    <= mn;
    csq.neg  <= ng[NORM_SH];
    csq.zero <= zr[NORM_SH];
    csq.side <= sd[NORM_SH];
    len2     <= 62'(sq[0]) + 62'(sq[1]) + 62'(sq[2]);
    csum     <= csq;
  end

  // integer square root, one digit a stage
  logic        qv [SQRT_STEPS+1];
  logic [63:0] sn [SQRT_STEPS+1];
  logic [63:0] sr [SQRT_STEPS+1];
  nrm_t        sc [SQRT_STEPS+1];

  assign qv[0] = vsum;
  assign sn[0] = 64'(len2);
  assign sr[0] = '0;
  assign sc[0] = csum;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] t;
    logic        ge;
    assign t  = sr[j] + BIT;
    assign ge = (sn[j] >= t);

    always_ff @(posedge clk) begin
      if (rst) qv[j+1] <= 1'b0;
      else     qv[j+1] <= qv[j];
    end

    always_ff @(posedge clk) begin
      sn[j+1] <= ge ? (sn[j] - t) : sn[j];
      sr[j+1] <= ge ? ((sr[j] >> 1) + BIT) : (sr[j] >> 1);
      sc[j+1] <= sc[j];
    end
  end

  // numerators with half the divisor for rounding
  logic             dv [DIV_STEPS+1];
  logic [2:0][60:0] rm [DIV_STEPS+1];
  logic [2:0][30:0] dq [DIV_STEPS+1];
  logic [30:0]      dr [DIV_STEPS+1];
  nrm_t             dc [DIV_STEPS+1];
  logic [30:0]      root;

  assign root = sr[SQRT_STEPS][30:0];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else     dv[0] <= qv[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rm[0][i] <= 61'({sc[SQRT_STEPS].m[i], 30'b0}) + 61'(root[30:1]);
    end
    dq[0] <= '0;
    dr[0] <= root;
    dc[0] <= sc[SQRT_STEPS];
  end

  // restoring division, one quotient bit a stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - j;
    logic [61:0]      dsh;
    logic [2:0][61:0] diff;
    logic [2:0]       ge;
    assign dsh = 62'(dr[j]) << SH;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        diff[i] = {1'b0, rm[j][i]} - dsh;
        ge[i]   = ({1'b0, rm[j][i]} >= dsh);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else     dv[j+1] <= dv[j];
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        rm[j+1][i] <= ge[i] ? diff[i][60:0] : rm[j][i];
        dq[j+1][i] <= dq[j][i] | (31'(ge[i]) << SH);
      end
      dr[j+1] <= dr[j];
      dc[j+1] <= dc[j];
    end
  end

  // apply signs
  always_ff @(posedge clk) begin
    if (rst) vld_out <= 1'b0;
    else     vld_out <= dv[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      unit_out[i] <= dc[DIV_STEPS].neg[i] ? -32'(dq[DIV_STEPS][i])
                                          : 32'(dq[DIV_STEPS][i]);
    end
    ok_out   <= !dc[DIV_STEPS].zero;
    side_out <= dc[DIV_STEPS].side;
  end

endmodule

// File: src/lav_cross.sv
// ----------------------------------------------------------------------------
// lav_cross: two-stage exact cross product a x b
// Six signed 32x32 products, then three differences at 64 bits.
// ----------------------------------------------------------------------------
module lav_cross import lav_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  vld_in,
  input  v32_t  a,
  input  v32_t  b,
  input  side_t side_in,
  output logic  vld_out,
  output v64_t  prod_out,
  output side_t side_out
);

  logic                    vld1;
  logic signed [5:0][63:0] p;
  side_t                   side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld_out <= 1'b0;
    end else begin
      vld1    <= vld_in;
      vld_out <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    p[0]  <= 64'($signed(a[1]) * $signed(b[2]));
    p[1]  <= 64'($signed(a[2]) * $signed(b[1]));
    p[2]  <= 64'($signed(a[2]) * $signed(b[0]));
    p[3]  <= 64'($signed(a[0]) * $signed(b[2]));
    p[4]  <= 64'($signed(a[0]) * $signed(b[1]));
    p[5]  <= 64'($signed(a[1]) * $signed(b[0]));
    side1 <= side_in;
    prod_out[0] <= p[0] - p[1];
    prod_out[1] <= p[2] - p[3];
    prod_out[2] <= p[4] - p[5];
    side_out    <= side1;
  end

endmodule

// File: src/lav_rows.sv
// ----------------------------------------------------------------------------
// lav_rows: up row rounding and row offsets
// Rounds s x v to Q2.30, forms -(row . eye) per row, saturates, and zeroes
// everything for a degenerate frame.
// ----------------------------------------------------------------------------
module lav_rows import lav_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   vld_in,
  input  v64_t   u_raw,
  input  side_t  side_in,
  output logic   vld_out,
  output block_t block_out
);

  localparam logic [63:0] HALF = 64'd1 << (AXIS_FRAC - 1);

  logic [4:0] vp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp      <= '0;
      vld_out <= 1'b0;
    end else begin
      vp      <= {vp[3:0], vld_in};
      vld_out <= vp[4];
    end
  end

  // round u to Q2.30, half away from zero
  logic [2:0][63:0] umag;
  logic [2:0][33:0] um;
  logic [2:0]       ung;
  side_t            sd1, sd2, sd3, sd4, sd5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      umag[i] = u_raw[i][63] ? -u_raw[i] : u_raw[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      um[i]  <= 34'((umag[i] + HALF) >> AXIS_FRAC);
      ung[i] <= u_raw[i][63];
    end
    sd1 <= side_in;
  end

  // saturate u
  v32_t uv, uv3, uv4, uv5;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (ung[i]) uv[i] <= (um[i] > 34'h080000000) ? 32'h80000000 : -um[i][31:0];
      else        uv[i] <= (um[i] > 34'h07FFFFFFF) ? 32'h7FFFFFFF : um[i][31:0];
    end
    sd2 <= sd1;
  end

  // dot products with the eye point
  v32_t                    rw [3];
  logic signed [63:0]      pr [3][3];
  logic signed [65:0]      dot [3];
  logic [2:0][35:0]        om;
  logic [2:0]              ong;
  logic [2:0][65:0]        dmag;

  always_comb begin
    rw[ROW_SIDE] = sd2.p;
    rw[ROW_UP]   = uv;
    rw[ROW_FWD]  = sd2.q;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        pr[k][i] <= 64'($signed(rw[k][i]) * $signed(sd2.eye[i]));
      end
    end
    uv3 <= uv;
    sd3 <= sd2;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dot[k] <= 66'(pr[k][0]) + 66'(pr[k][1]) + 66'(pr[k][2]);
    end
    uv4 <= uv3;
    sd4 <= sd3;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dmag[k] = dot[k][65] ? 66'(-dot[k]) : 66'(dot[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      om[k]  <= 36'((dmag[k] + 66'(HALF)) >> AXIS_FRAC);
      ong[k] <= dot[k][65];
    end
    uv5 <= uv4;
    sd5 <= sd4;
  end

  // negate, saturate, blank a degenerate frame
  logic [2:0][31:0] offs;
  v32_t             axes [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (ong[k]) offs[k] = (om[k] > 36'h07FFFFFFF) ? 32'h7FFFFFFF : om[k][31:0];
      else        offs[k] = (om[k] > 36'h080000000) ? 32'h80000000 : -om[k][31:0];
    end
    axes[ROW_SIDE] = sd5.p;
    axes[ROW_UP]   = uv5;
    axes[ROW_FWD]  = sd5.q;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      block_out.rows[k].axis <= sd5.flag ? axes[k] : '0;
      block_out.rows[k].off  <= sd5.flag ? offs[k] : '0;
    end
    block_out.degen <= !sd5.flag;
  end

endmodule

// File: src/lav_serial.sv
// ----------------------------------------------------------------------------
// lav_serial: row serialiser
// Takes a finished frame and puts its three rows out on consecutive cycles.
// ----------------------------------------------------------------------------
module lav_serial import lav_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        vld_in,
  input  block_t      block_in,
  output logic        done,
  output logic [1:0]  row_index,
  output logic [31:0] axis_x,
  output logic [31:0] axis_y,
  output logic [31:0] axis_z,
  output logic [31:0] offset,
  output logic        degenerate,
  output logic        last_row
);

  // phase names the next row to send; side means nothing pending
  block_t     hold;
  logic [1:0] phase;
  row_t       sel;

  always_comb begin
    if (vld_in) sel = block_in.rows[ROW_SIDE];
    else        sel = hold.rows[phase];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      phase <= ROW_SIDE;
    end else if (vld_in) begin
      done  <= 1'b1;
      phase <= ROW_UP;
    end else if (phase != ROW_SIDE) begin
      done  <= 1'b1;
      phase <= (phase == ROW_UP) ? ROW_FWD : ROW_SIDE;
    end else begin
      done  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_in) hold <= block_in;
    row_index  <= vld_in ? ROW_SIDE : phase;
    axis_x     <= sel.axis[0];
    axis_y     <= sel.axis[1];
    axis_z     <= sel.axis[2];
    offset     <= sel.off;
    degenerate <= vld_in ? block_in.degen : hold.degen;
    last_row   <= !vld_in && (phase == ROW_FWD);
  end

endmodule

// File: src/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix: fixed-point look-at view matrix rows
// Eye, target and up in Q16.16 in; rows side, up and forward out, each a
// Q2.30 basis vector with its saturated Q16.16 offset -(row . eye).
// ----------------------------------------------------------------------------
//
//  channel   signals                                   handshake
//  --------  ----------------------------------------  ---------------------
//  request   eye_*, target_*, upward_* (9 x s32)       start && !busy
//  result    row_index, axis_*, offset, degenerate,    done, one cycle each,
//            last_row                                  no back-pressure
//
// Requests are spaced out: each request yields three rows on the single
// result port, so busy stays high after an accept while gap counts down.
// The path from accept to row 0 runs through two normalisers of 75 stages
// each (32 root stages, 31 quotient stages), two cross-product pairs of 2
// stages, the 6 stage row/offset unit, input and output registers.
// Rows follow on consecutive cycles. Reset is synchronous and clears all
// valid bits; the pipeline never stalls since the receiver cannot hold off.
// ----------------------------------------------------------------------------
module look_at_view_matrix import lav_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] eye_x,
  input  logic [31:0] eye_y,
  input  logic [31:0] eye_z,
  input  logic [31:0] target_x,
  input  logic [31:0] target_y,
  input  logic [31:0] target_z,
  input  logic [31:0] upward_x,
  input  logic [31:0] upward_y,
  input  logic [31:0] upward_z,
  output logic        done,
  output logic [1:0]  row_index,
  output logic [31:0] axis_x,
  output logic [31:0] axis_y,
  output logic [31:0] axis_z,
  output logic [31:0] offset,
  output logic        degenerate,
  output logic        last_row
);

  // request spacing: busy after each accept while gap counts down
  logic [1:0] gap;
  logic       take;

  assign take = start && !busy;
  assign busy = (gap != 2'd0);

  always_ff @(posedge clk) begin
    if (rst)              gap <= 2'd0;
    else if (take)        gap <= 2'd2;
    else if (gap != 2'd0) gap <= gap - 2'd1;
  end

  // input register: forward difference at full 33-bit precision
  logic vld_a;
  v32_t eye_a, up_a;
  v64_t fwd_a;

  always_ff @(posedge clk) begin
    if (rst) vld_a <= 1'b0;
    else     vld_a <= take;
  end

  always_ff @(posedge clk) begin
    eye_a    <= {eye_z, eye_y, eye_x};
    up_a     <= {upward_z, upward_y, upward_x};
    fwd_a[0] <= 64'($signed(target_x)) - 64'($signed(eye_x));
    fwd_a[1] <= 64'($signed(target_y)) - 64'($signed(eye_y));
    fwd_a[2] <= 64'($signed(target_z)) - 64'($signed(eye_z));
  end

  // forward vector
  logic  vld_f, ok_f;
  v32_t  fwd_u;
  side_t side_a, side_f;

  assign side_a = '{eye: eye_a, p: up_a, q: '0, flag: 1'b1};

  lav_norm u_norm_fwd (
    .clk(clk), .rst(rst), .vld_in(vld_a), .vec_in(fwd_a), .side_in(side_a),
    .vld_out(vld_f), .unit_out(fwd_u), .ok_out(ok_f), .side_out(side_f)
  );

  // forward x up
  logic  vld_c;
  v64_t  side_raw;
  side_t side_b, side_c;

  assign side_b = '{eye: side_f.eye, p: '0, q: fwd_u, flag: ok_f};

  lav_cross u_cross_side (
    .clk(clk), .rst(rst), .vld_in(vld_f), .a(fwd_u), .b(side_f.p),
    .side_in(side_b), .vld_out(vld_c), .prod_out(side_raw), .side_out(side_c)
  );

  // side vector
  logic  vld_s, ok_s;
  v32_t  side_u;
  side_t side_s, side_d;

  lav_norm u_norm_side (
    .clk(clk), .rst(rst), .vld_in(vld_c), .vec_in(side_raw), .side_in(side_c),
    .vld_out(vld_s), .unit_out(side_u), .ok_out(ok_s), .side_out(side_s)
  );

  // side x forward gives the up row
  logic  vld_u;
  v64_t  up_raw;
  side_t side_e;

  assign side_d = '{eye: side_s.eye, p: side_u, q: side_s.q,
                    flag: side_s.flag && ok_s};

  lav_cross u_cross_up (
    .clk(clk), .rst(rst), .vld_in(vld_s), .a(side_u), .b(side_s.q),
    .side_in(side_d), .vld_out(vld_u), .prod_out(up_raw), .side_out(side_e)
  );

  // rows with offsets
  logic   vld_r;
  block_t frame;

  lav_rows u_rows (
    .clk(clk), .rst(rst), .vld_in(vld_u), .u_raw(up_raw), .side_in(side_e),
    .vld_out(vld_r), .block_out(frame)
  );

  lav_serial u_serial (
    .clk(clk), .rst(rst), .vld_in(vld_r), .block_in(frame),
    .done(done), .row_index(row_index), .axis_x(axis_x), .axis_y(axis_y),
    .axis_z(axis_z), .offset(offset), .degenerate(degenerate),
    .last_row(last_row)
  );

  // an accepted request keeps busy high while the gap counter runs down
  a_gap: assert property (@(posedge clk) disable iff (rst)
    take |=> busy ##1 busy)
    else $error("request spacing broken");

  // rows of one frame come back to back, side then up then forward
  a_row_seq: assert property (@(posedge clk) disable iff (rst)
    done && row_index == ROW_SIDE |=> done && row_index == ROW_UP)
    else $error("up row missing after side row");

  a_last: assert property (@(posedge clk) disable iff (rst)
    done && row_index == ROW_UP |=> done && last_row && row_index == ROW_FWD)
    else $error("forward row missing or not marked last");

  // the degenerate flag belongs to the frame, not to a row
  a_degen: assert property (@(posedge clk) disable iff (rst)
    done && !last_row |=> degenerate == $past(degenerate))
    else $error("degenerate flag changed within a frame");

endmodule

// File: test/lav_checker.sv
// ----------------------------------------------------------------------------
// lav_checker: row predictor and scoreboard for the look-at view matrix
// Watches accepted requests, works out the three rows each one gives, and
// compares every done strobe with the oldest row still awaited.
// ----------------------------------------------------------------------------
module lav_checker import lav_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] eye_x,
  input  logic [31:0] eye_y,
  input  logic [31:0] eye_z,
  input  logic [31:0] target_x,
  input  logic [31:0] target_y,
  input  logic [31:0] target_z,
  input  logic [31:0] upward_x,
  input  logic [31:0] upward_y,
  input  logic [31:0] upward_z,
  input  logic        done,
  input  logic [1:0]  row_index,
  input  logic [31:0] axis_x,
  input  logic [31:0] axis_y,
  input  logic [31:0] axis_z,
  input  logic [31:0] offset,
  input  logic        degenerate,
  input  logic        last_row,
  output int          fails,
  output int          pending
);

  typedef longint vec_t [3];

  typedef struct {
    logic [1:0]  idx;
    logic [31:0] ax [3];
    logic [31:0] off;
    logic        deg;
    logic        last;
  } view_row_t;

  view_row_t rows_due [$];

  function automatic longint unsigned magn(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint round_shr(longint x, int sh);
    longint unsigned m;
    m = (magn(x) + (64'd1 << (sh - 1))) >> sh;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // scale so the largest magnitude sits in [2^29, 2^30), then divide by root
  function automatic bit to_unit(input vec_t vin, output vec_t vout);
    longint unsigned m [3];
    longint unsigned top, len2, r, q;
    top = 0;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = magn(vin[i]);
      if (m[i] > top) top = m[i];
      vout[i] = 0;
    end
    if (top == 0) return 1'b0;
    while (top >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      top = top >> 1;
    end
    while (top < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      top = top << 1;
    end
    for (int i = 0; i < 3; i++) len2 = len2 + m[i] * m[i];
    r = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << AXIS_FRAC) + (r >> 1)) / r;
      vout[i] = vin[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  task automatic predict_rows(input logic [31:0] e [3], input logic [31:0] t [3],
                              input logic [31:0] w [3]);
    vec_t eye, up, d, v, c, s, u;
    longint basis [3][3];
    longint dot;
    bit ok;
    view_row_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'(signed'(e[i]));
      up[i]  = longint'(signed'(w[i]));
      d[i]   = longint'(signed'(t[i])) - eye[i];
    end
    ok = to_unit(d, v);
    if (ok) begin
      c[0] = v[1] * up[2] - v[2] * up[1];
      c[1] = v[2] * up[0] - v[0] * up[2];
      c[2] = v[0] * up[1] - v[1] * up[0];
      ok = to_unit(c, s);
    end
    if (ok) begin
      u[0] = clip32(round_shr(s[1] * v[2] - s[2] * v[1], AXIS_FRAC));
      u[1] = clip32(round_shr(s[2] * v[0] - s[0] * v[2], AXIS_FRAC));
      u[2] = clip32(round_shr(s[0] * v[1] - s[1] * v[0], AXIS_FRAC));
    end
    for (int i = 0; i < 3; i++) begin
      basis[0][i] = ok ? s[i] : 0;
      basis[1][i] = ok ? u[i] : 0;
      basis[2][i] = ok ? v[i] : 0;
    end
    for (int k = 0; k < 3; k++) begin
      dot = 0;
      for (int i = 0; i < 3; i++) dot = dot + basis[k][i] * eye[i];
      r.idx  = (k == 0) ? ROW_SIDE : (k == 1) ? ROW_UP : ROW_FWD;
      for (int i = 0; i < 3; i++) r.ax[i] = basis[k][i][31:0];
      r.off  = ok ? 32'(clip32(-round_shr(dot, AXIS_FRAC))) : 32'd0;
      r.deg  = !ok;
      r.last = (k == 2);
      rows_due.push_back(r);
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  assign pending = rows_due.size();

  initial fails = 0;

  always @(posedge clk) begin
    view_row_t x;
    if (!rst && start && !busy)
      predict_rows('{eye_x, eye_y, eye_z}, '{target_x, target_y, target_z},
                   '{upward_x, upward_y, upward_z});
    if (!rst && done) begin
      if (rows_due.size() == 0) begin
        report("unexpected row", {30'd0, row_index}, 32'd0);
      end else begin
        x = rows_due.pop_front();
        if (row_index !== x.idx) report("row_index", {30'd0, row_index}, {30'd0, x.idx});
        if (axis_x !== x.ax[0]) report("axis_x", axis_x, x.ax[0]);
        if (axis_y !== x.ax[1]) report("axis_y", axis_y, x.ax[1]);
        if (axis_z !== x.ax[2]) report("axis_z", axis_z, x.ax[2]);
        if (offset !== x.off) report("offset", offset, x.off);
        if (degenerate !== x.deg) report("degenerate", {31'd0, degenerate}, {31'd0, x.deg});
        if (last_row !== x.last) report("last_row", {31'd0, last_row}, {31'd0, x.last});
      end
    end
  end

endmodule

// File: test/tb_look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// tb_look_at_view_matrix: stimulus and verdict for the look-at view matrix
// Directed corner requests then random ones with idle bursts; the checker
// beside the block predicts and compares every row.
// ----------------------------------------------------------------------------
module tb_look_at_view_matrix;
  import lav_pkg::*;

  localparam int LATENCY   = 162;
  localparam int MAX_CYCLE = 200000;
  localparam int N_RANDOM  = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, degenerate, last_row;
  logic [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic [31:0] upward_x = '0, upward_y = '0, upward_z = '0;
  logic [1:0]  row_index;
  logic [31:0] axis_x, axis_y, axis_z, offset;
  int fails, pending;
  int cycle = 0;
  bit quiet = 0;   // no idling near the end

  always #10 clk = ~clk;

  look_at_view_matrix DUT (.*);
  lav_checker u_checker (.*);

  // run guard
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("** look_at_view_matrix: FAILED **");
      $finish;
    end
  end

  // present one request and hold it until the block takes it
  task automatic send_req(input logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
    eye_x <= ex; eye_y <= ey; eye_z <= ez;
    target_x <= tx; target_y <= ty; target_z <= tz;
    upward_x <= ux; upward_y <= uy; upward_z <= uz;
    start <= 1'b1;
    do @(posedge clk); while (!(start && !busy));
  endtask

  // idle burst on the request side, sometimes none
  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return {$urandom_range(0, 1) == 1 ? 2'b11 : 2'b00, 30'($urandom)};
    endcase
  endfunction

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;

  initial begin
    logic [31:0] e [3], t [3], w [3];
    int k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // plain frame: looking down -z with y up
    send_req(0, 0, 0, 0, 0, -ONE, 0, ONE, 0);
    send_req(ONE, 2*ONE, 3*ONE, 0, 0, 0, 0, ONE, 0);
    // target equal to eye
    send_req(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0);
    // up of zero length
    send_req(0, 0, 0, ONE, 0, 0, 0, 0, 0);
    // up parallel to forward, both senses
    send_req(0, 0, 0, 0, 3*ONE, 0, 0, ONE, 0);
    send_req(0, 0, 0, 0, 3*ONE, 0, 0, -ONE, 0);
    // coordinate extremes
    send_req(MINV, MINV, MINV, MAXV, MAXV, MAXV, 0, ONE, 0);
    send_req(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV, MINV);
    send_req(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MAXV);
    // offset saturating both ways
    send_req(MINV, MINV, MINV, 0, 0, 0, MINV, MAXV, 0);
    send_req(MAXV, MAXV, MAXV, 0, 0, 0, 0, MINV, MAXV);
    send_req(MINV, 0, 0, 0, 0, 0, 0, ONE, 0);
    // tiny vectors scaled up, huge ones scaled down
    send_req(0, 0, 0, 1, 0, 0, 0, 0, 1);
    send_req(0, 0, 0, 1, 1, 1, 1, 0, 0);
    send_req(1, 1, 1, 0, 0, 0, MINV, MINV, MAXV);
    send_req(32'hffff_ffff, 0, 0, 0, 32'hffff_ffff, 0, 0, 0, 32'hffff_ffff);
    send_req(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
             32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);

    // hold off until the pipe is empty
    start <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);

    for (k = 0; k < N_RANDOM; k++) begin
      if (k > N_RANDOM - 20) quiet = 1;
      for (int i = 0; i < 3; i++) begin
        e[i] = rnd_coord();
        t[i] = rnd_coord();
        w[i] = rnd_coord();
      end
      case ($urandom_range(0, 15))
        0: t = e;                                           // no forward vector
        1: for (int i = 0; i < 3; i++) w[i] = (t[i] - e[i]) >>> 2;  // often parallel
        2: w = '{0, 0, 0};
        default: ;
      endcase
      send_req(e[0], e[1], e[2], t[0], t[1], t[2], w[0], w[1], w[2]);
      maybe_idle();
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (fails == 0) begin
      $display("** look_at_view_matrix: PASSED **");
    end else begin
      $display("** look_at_view_matrix: FAILED **");
    end
    $finish;
  end

endmodule
